### sv/stunfp_pkg.sv
// ----------------------------------------------------------------------------
// STUN fingerprint checker package
// Word types, status codes, walk phases and the byte-wide CRC-32 step.
// ----------------------------------------------------------------------------
package stunfp_pkg;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CountW-1:0] HdrSize = 17'd20;
  localparam logic [CountW-1:0] AttrHdrSize = 17'd4;
  localparam logic [15:0] FpSize = 16'd4;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;
  localparam logic [31:0] FpXor = 32'h5354554E;
  localparam logic [7:0] TopBitsMask = 8'hC0;

  localparam logic [31:0] CookieReset = 32'h2112A442;
  localparam logic [15:0] FpTypeReset = 16'h8028;

  // configuration register indexes
  localparam logic CFG_MAGIC_COOKIE = 1'b0;
  localparam logic CFG_FP_ATTR_TYPE = 1'b1;

  // status codes
  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_SHORT = 4'd1;
  localparam logic [3:0] ST_TOP_BITS = 4'd2;
  localparam logic [3:0] ST_UNALIGNED = 4'd3;
  localparam logic [3:0] ST_COOKIE = 4'd4;
  localparam logic [3:0] ST_TRUNCATED = 4'd5;
  localparam logic [3:0] ST_TRAILING = 4'd6;
  localparam logic [3:0] ST_ATTR_HDR = 4'd7;
  localparam logic [3:0] ST_ATTR_VALUE = 4'd8;
  localparam logic [3:0] ST_FP_SIZE = 4'd9;
  localparam logic [3:0] ST_FP_NOT_LAST = 4'd10;
  localparam logic [3:0] ST_FP_MISSING = 4'd11;
  localparam logic [3:0] ST_MISMATCH = 4'd12;

  typedef enum logic [3:0] {
    PH_SEARCH   = 4'b0001,
    PH_ATTR_HDR = 4'b0010,
    PH_FP_VALUE = 4'b0100,
    PH_DONE     = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] computed_fingerprint;
  } out_word_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc_in, logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/stun_fingerprint_checker.sv
// ----------------------------------------------------------------------------
// STUN fingerprint checker
// Streams a datagram a byte per word, checks the header, walks the attributes
// and compares the fingerprint attribute with the CRC-32 of the bytes before it.
// ----------------------------------------------------------------------------
// The status word is registered as the last byte is taken.
// Throughput: one byte per cycle; byte-wide CRC step and field tracking per cycle.
// A last byte waits only while an earlier status is held by the output stall.
// Reset clears the datagram state and loads the register defaults; no clear pass.
// ----------------------------------------------------------------------------
module stun_fingerprint_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  stunfp_pkg::in_word_t  in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output stunfp_pkg::out_word_t out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  logic [31:0] cookie_q;
  logic [15:0] fp_type_q;

  logic [stunfp_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [15:0] decl_len_q, decl_len_d;
  logic        top_bad_q, top_bad_d;
  logic        cookie_bad_q, cookie_bad_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_attr_q, crc_attr_d;
  logic [stunfp_pkg::CountW-1:0] next_off_q, next_off_d;
  logic [15:0] attr_type_q, attr_type_d;
  logic [15:0] attr_len_q, attr_len_d;
  stunfp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  walk_err_q, walk_err_d;
  logic [31:0] rx_fp_q, rx_fp_d;

  logic                  out_valid_q, out_valid_d;
  stunfp_pkg::out_word_t out_word_q, out_word_d;

  logic        in_acc, out_acc;
  logic [7:0]  b;
  logic [stunfp_pkg::CountW-1:0] i, total, k;
  logic [17:0] attr_end, padded;
  logic [16:0] len_up;
  logic [15:0] len_new;
  logic [7:0]  want;
  logic [3:0]  status;
  logic [31:0] computed;

  assign b = in_word_i.data_byte;
  assign i = cnt_q;
  assign in_stall_o = out_valid_q && out_stall_i && in_word_i.last_byte;
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o = out_word_q;

  always_comb begin
    decl_len_d = decl_len_q;
    top_bad_d = top_bad_q;
    cookie_bad_d = cookie_bad_q;
    crc_attr_d = crc_attr_q;
    next_off_d = next_off_q;
    attr_type_d = attr_type_q;
    attr_len_d = attr_len_q;
    phase_d = phase_q;
    walk_err_d = walk_err_q;
    rx_fp_d = rx_fp_q;

    if (i == '0 && (b & stunfp_pkg::TopBitsMask) != 8'h00) begin
      top_bad_d = 1'b1;
    end
    if (i == 17'd2) begin
      decl_len_d = {b, decl_len_q[7:0]};
    end
    if (i == 17'd3) begin
      decl_len_d = {decl_len_q[15:8], b};
    end
    unique case (i[1:0])
      2'd0:    want = cookie_q[31:24];
      2'd1:    want = cookie_q[23:16];
      2'd2:    want = cookie_q[15:8];
      default: want = cookie_q[7:0];
    endcase
    if (i >= 17'd4 && i <= 17'd7 && want != b) begin
      cookie_bad_d = 1'b1;
    end

    total = stunfp_pkg::HdrSize + {1'b0, decl_len_d};
    k = i - next_off_q;
    attr_end = {1'b0, i} + {1'b0, stunfp_pkg::AttrHdrSize};
    len_new = {attr_len_q[15:8], b};
    len_up = ({1'b0, len_new} + 17'd3) & ~17'd3;
    padded = {1'b0, next_off_q} + {1'b0, stunfp_pkg::AttrHdrSize} + {1'b0, len_up};

    if (i >= stunfp_pkg::HdrSize && i < total) begin
      unique case (phase_q)
        stunfp_pkg::PH_SEARCH: begin
          if (i == next_off_q) begin
            if (attr_end > {1'b0, total}) begin
              walk_err_d = stunfp_pkg::ST_ATTR_HDR;
              phase_d = stunfp_pkg::PH_DONE;
            end else begin
              crc_attr_d = crc_q;
              attr_type_d = {b, 8'h00};
              phase_d = stunfp_pkg::PH_ATTR_HDR;
            end
          end
        end
        stunfp_pkg::PH_ATTR_HDR: begin
          if (k == 17'd1) begin
            attr_type_d = {attr_type_q[15:8], b};
          end else if (k == 17'd2) begin
            attr_len_d = {b, 8'h00};
          end else if (k == 17'd3) begin
            attr_len_d = len_new;
            if (padded > {1'b0, total}) begin
              walk_err_d = stunfp_pkg::ST_ATTR_VALUE;
              phase_d = stunfp_pkg::PH_DONE;
            end else if (attr_type_q == fp_type_q) begin
              if (len_new != stunfp_pkg::FpSize) begin
                walk_err_d = stunfp_pkg::ST_FP_SIZE;
                phase_d = stunfp_pkg::PH_DONE;
              end else if (padded != {1'b0, total}) begin
                walk_err_d = stunfp_pkg::ST_FP_NOT_LAST;
                phase_d = stunfp_pkg::PH_DONE;
              end else begin
                rx_fp_d = '0;
                phase_d = stunfp_pkg::PH_FP_VALUE;
              end
            end else begin
              next_off_d = padded[stunfp_pkg::CountW-1:0];
              phase_d = stunfp_pkg::PH_SEARCH;
            end
          end
        end
        stunfp_pkg::PH_FP_VALUE: begin
          rx_fp_d = {rx_fp_q[23:0], b};
          if (k == 17'd7) begin
            phase_d = stunfp_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end

    crc_d = stunfp_pkg::crc_byte(crc_q, b);
    cnt_d = (cnt_q != stunfp_pkg::CountMax) ? cnt_q + 17'd1 : cnt_q;

    computed = '0;
    priority if (cnt_d < stunfp_pkg::HdrSize) begin
      status = stunfp_pkg::ST_SHORT;
    end else if (top_bad_d) begin
      status = stunfp_pkg::ST_TOP_BITS;
    end else if (decl_len_d[1:0] != 2'b00) begin
      status = stunfp_pkg::ST_UNALIGNED;
    end else if (cookie_bad_d) begin
      status = stunfp_pkg::ST_COOKIE;
    end else if (cnt_d < total) begin
      status = stunfp_pkg::ST_TRUNCATED;
    end else if (cnt_d != total) begin
      status = stunfp_pkg::ST_TRAILING;
    end else if (walk_err_d != stunfp_pkg::ST_OK) begin
      status = walk_err_d;
    end else if (phase_d != stunfp_pkg::PH_DONE) begin
      status = stunfp_pkg::ST_FP_MISSING;
    end else begin
      computed = ~crc_attr_d ^ stunfp_pkg::FpXor;
      status = (computed == rx_fp_d) ? stunfp_pkg::ST_OK : stunfp_pkg::ST_MISMATCH;
    end

    out_word_d.status = status;
    out_word_d.computed_fingerprint = computed;

    out_valid_d = out_valid_q && !out_acc;
    if (in_acc && in_word_i.last_byte) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cookie_q <= stunfp_pkg::CookieReset;
      fp_type_q <= stunfp_pkg::FpTypeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        stunfp_pkg::CFG_MAGIC_COOKIE: cookie_q <= cfg_data_i;
        stunfp_pkg::CFG_FP_ATTR_TYPE: fp_type_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      decl_len_q <= '0;
      top_bad_q <= 1'b0;
      cookie_bad_q <= 1'b0;
      crc_q <= stunfp_pkg::CrcInit;
      crc_attr_q <= stunfp_pkg::CrcInit;
      next_off_q <= stunfp_pkg::HdrSize;
      attr_type_q <= '0;
      attr_len_q <= '0;
      phase_q <= stunfp_pkg::PH_SEARCH;
      walk_err_q <= stunfp_pkg::ST_OK;
      rx_fp_q <= '0;
    end else if (in_acc) begin
      if (in_word_i.last_byte) begin
        cnt_q <= '0;
        decl_len_q <= '0;
        top_bad_q <= 1'b0;
        cookie_bad_q <= 1'b0;
        crc_q <= stunfp_pkg::CrcInit;
        crc_attr_q <= stunfp_pkg::CrcInit;
        next_off_q <= stunfp_pkg::HdrSize;
        attr_type_q <= '0;
        attr_len_q <= '0;
        phase_q <= stunfp_pkg::PH_SEARCH;
        walk_err_q <= stunfp_pkg::ST_OK;
        rx_fp_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        decl_len_q <= decl_len_d;
        top_bad_q <= top_bad_d;
        cookie_bad_q <= cookie_bad_d;
        crc_q <= crc_d;
        crc_attr_q <= crc_attr_d;
        next_off_q <= next_off_d;
        attr_type_q <= attr_type_d;
        attr_len_q <= attr_len_d;
        phase_q <= phase_d;
        walk_err_q <= walk_err_d;
        rx_fp_q <= rx_fp_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_word_i.last_byte) begin
      out_word_q <= out_word_d;
    end
  end

endmodule
